// ----- hdl/obf_pkg.sv -----
// ----------------------------------------------------------------------------
// Orthonormal basis package
// Shared widths and constants for the basis pipeline and its cells.
// ----------------------------------------------------------------------------
package obf_pkg;

	localparam int OUT_W       = 16;
	localparam int EPS_W       = 15;
	localparam int EPS_RESET   = 16;
	localparam int IN_FRAC     = 12;
	localparam int NORM_W      = 64;
	localparam int SHIFT_STEPS = 6;
	localparam int SQRT_STEPS  = 32;
	localparam int MANT_W      = 31;
	localparam int ROOT_W      = 32;
	localparam int OUT_WORDS   = 9;

	typedef logic [OUT_W-1:0] word_t;

endpackage

// ----- hdl/obf_if.sv -----
// ----------------------------------------------------------------------------
// Orthonormal basis channels
// Valid/ready channels for the vector input, basis output and configuration.
// ----------------------------------------------------------------------------
interface obf_vec_if #(parameter int IN_WIDTH = 24);
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] vec_x;
	logic signed [IN_WIDTH-1:0] vec_y;
	logic signed [IN_WIDTH-1:0] vec_z;
	logic                       already_unit;

	modport source(output valid, vec_x, vec_y, vec_z, already_unit, input ready);
	modport sink(input valid, vec_x, vec_y, vec_z, already_unit, output ready);
endinterface

interface obf_basis_if;
	import obf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] first_x;
	logic signed [OUT_W-1:0] first_y;
	logic signed [OUT_W-1:0] first_z;
	logic signed [OUT_W-1:0] second_x;
	logic signed [OUT_W-1:0] second_y;
	logic signed [OUT_W-1:0] second_z;
	logic signed [OUT_W-1:0] third_x;
	logic signed [OUT_W-1:0] third_y;
	logic signed [OUT_W-1:0] third_z;

	modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		third_x, third_y, third_z, input ready);
	modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		third_x, third_y, third_z, output ready);
endinterface

interface obf_cfg_if;
	import obf_pkg::*;
	logic             valid;
	logic             ready;
	logic [EPS_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- hdl/obf_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// One step of the bitwise integer square root, registered, with a sideband.
// ----------------------------------------------------------------------------
module obf_sqrt_cell #(
	parameter int STEP   = 0,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [obf_pkg::NORM_W-1:0]  n_in,
	input  logic [obf_pkg::NORM_W-1:0]  r_in,
	input  logic [SIDE_W-1:0]           side_in,
	output logic                        out_v,
	output logic [obf_pkg::NORM_W-1:0]  n_out,
	output logic [obf_pkg::NORM_W-1:0]  r_out,
	output logic [SIDE_W-1:0]           side_out
);
	import obf_pkg::*;

	localparam logic [NORM_W-1:0] BIT = NORM_W'(1) << (NORM_W - 2 - 2 * STEP);

	logic              v_q;
	logic [NORM_W-1:0] n_q;
	logic [NORM_W-1:0] r_q;
	logic [SIDE_W-1:0] side_q;
	logic [NORM_W-1:0] trial;

	assign trial = r_in + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_in >= trial) begin
				n_q <= n_in - trial;
				r_q <= (r_in >> 1) + BIT;
			end else begin
				n_q <= n_in;
				r_q <= r_in >> 1;
			end
			side_q <= side_in;
		end
	end

	assign out_v    = v_q;
	assign n_out    = n_q;
	assign r_out    = r_q;
	assign side_out = side_q;

endmodule

// ----- hdl/obf_div_cell.sv -----
// ----------------------------------------------------------------------------
// Division cell
// One restoring quotient bit for three lanes sharing one divisor, registered.
// ----------------------------------------------------------------------------
module obf_div_cell #(
	parameter int POS    = 0,
	parameter int DW     = 47,
	parameter int QW     = 15,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic [DW-1:0]               rem_in [3],
	input  logic [QW-1:0]               q_in [3],
	input  logic [obf_pkg::ROOT_W-1:0]  root_in,
	input  logic [SIDE_W-1:0]           side_in,
	output logic                        out_v,
	output logic [DW-1:0]               rem_out [3],
	output logic [QW-1:0]               q_out [3],
	output logic [obf_pkg::ROOT_W-1:0]  root_out,
	output logic [SIDE_W-1:0]           side_out
);
	import obf_pkg::*;

	logic              v_q;
	logic [DW-1:0]     rem_q [3];
	logic [QW-1:0]     q_q [3];
	logic [ROOT_W-1:0] root_q;
	logic [SIDE_W-1:0] side_q;
	logic [DW-1:0]     dvs;

	assign dvs = DW'(root_in) << POS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_in[i] >= dvs) begin
					rem_q[i] <= rem_in[i] - dvs;
					q_q[i]   <= q_in[i] | (QW'(1) << POS);
				end else begin
					rem_q[i] <= rem_in[i];
					q_q[i]   <= q_in[i];
				end
			end
			root_q <= root_in;
			side_q <= side_in;
		end
	end

	assign out_v    = v_q;
	assign rem_out  = rem_q;
	assign q_out    = q_q;
	assign root_out = root_q;
	assign side_out = side_q;

endmodule

// ----- hdl/obf_norm.sv -----
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a 3D magnitude vector to unit length: alignment, squares, a chain of
// square root cells and a chain of division cells.
// ----------------------------------------------------------------------------
module obf_norm #(
	parameter int MAG_W  = 24,
	parameter int F      = 14,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [MAG_W-1:0]    mag [3],
	input  logic [2:0]          neg,
	input  logic [SIDE_W-1:0]   side,
	output logic                out_v,
	output logic signed [F+1:0] res [3],
	output logic [SIDE_W-1:0]   side_out
);
	import obf_pkg::*;

	localparam int QW     = F + 1;
	localparam int DW     = F + ROOT_W + 1;
	localparam int SQ_SB  = 3 * MANT_W + 4 + SIDE_W;
	localparam int DIV_SB = 4 + SIDE_W;
	localparam int LAST   = SHIFT_STEPS - 1;

	logic              sh_v_s [SHIFT_STEPS];
	logic [NORM_W-1:0] sh_m_s [SHIFT_STEPS][3];
	logic [2:0]        sh_n_s [SHIFT_STEPS];
	logic [SIDE_W-1:0] sh_d_s [SHIFT_STEPS];

	for (genvar k = 0; k < SHIFT_STEPS; k++) begin : g_sh
		localparam int STEP = 1 << (SHIFT_STEPS - 1 - k);
		logic [NORM_W-1:0] pm [3];
		logic              pv;
		logic [2:0]        pn;
		logic [SIDE_W-1:0] ps;
		logic [NORM_W-1:0] orv;
		logic              up;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					pm[i] = NORM_W'(mag[i]);
				end
				pv = in_v;
				pn = neg;
				ps = side;
			end
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					pm[i] = sh_m_s[k-1][i];
				end
				pv = sh_v_s[k-1];
				pn = sh_n_s[k-1];
				ps = sh_d_s[k-1];
			end
		end

		assign orv = pm[0] | pm[1] | pm[2];
		assign up  = (orv[NORM_W-1 -: STEP] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sh_v_s[k] <= 1'b0;
			end else if (en) begin
				sh_v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					sh_m_s[k][i] <= up ? (pm[i] << STEP) : pm[i];
				end
				sh_n_s[k] <= pn;
				sh_d_s[k] <= ps;
			end
		end
	end

	logic [MANT_W-1:0] mant [3];
	logic              is_zero;
	logic [NORM_W-1:0] or_last;

	assign or_last = sh_m_s[LAST][0] | sh_m_s[LAST][1] | sh_m_s[LAST][2];
	assign is_zero = !or_last[NORM_W-1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mant[i] = sh_m_s[LAST][i][NORM_W-1 -: MANT_W];
		end
	end

	logic                  sq_v_s;
	logic [2*MANT_W-1:0]   sq_s [3];
	logic [SQ_SB-1:0]      sq_sb_s;
	logic                  sum_v_s;
	logic [NORM_W-1:0]     sum_s;
	logic [SQ_SB-1:0]      sum_sb_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s  <= 1'b0;
			sum_v_s <= 1'b0;
		end else if (en) begin
			sq_v_s  <= sh_v_s[LAST];
			sum_v_s <= sq_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s[i] <= (2*MANT_W)'(mant[i]) * (2*MANT_W)'(mant[i]);
			end
			sq_sb_s  <= {sh_d_s[LAST], is_zero, sh_n_s[LAST], mant[2], mant[1], mant[0]};
			sum_s    <= NORM_W'(sq_s[0]) + NORM_W'(sq_s[1]) + NORM_W'(sq_s[2]);
			sum_sb_s <= sq_sb_s;
		end
	end

	wire              rt_v [SQRT_STEPS+1];
	wire [NORM_W-1:0] rt_n [SQRT_STEPS+1];
	wire [NORM_W-1:0] rt_r [SQRT_STEPS+1];
	wire [SQ_SB-1:0]  rt_sb [SQRT_STEPS+1];

	assign rt_v[0]  = sum_v_s;
	assign rt_n[0]  = sum_s;
	assign rt_r[0]  = '0;
	assign rt_sb[0] = sum_sb_s;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_rt
		obf_sqrt_cell #(.STEP(k), .SIDE_W(SQ_SB)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_v    (rt_v[k]),
			.n_in    (rt_n[k]),
			.r_in    (rt_r[k]),
			.side_in (rt_sb[k]),
			.out_v   (rt_v[k+1]),
			.n_out   (rt_n[k+1]),
			.r_out   (rt_r[k+1]),
			.side_out(rt_sb[k+1])
		);
	end

	logic [ROOT_W-1:0] root;
	logic [SQ_SB-1:0]  rsb;
	logic [MANT_W-1:0] rm [3];

	assign root = rt_r[SQRT_STEPS][ROOT_W-1:0];
	assign rsb  = rt_sb[SQRT_STEPS];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rm[i] = rsb[i*MANT_W +: MANT_W];
		end
	end

	logic              dp_v_s;
	logic [DW-1:0]     dp_rem_s [3];
	logic [ROOT_W-1:0] dp_root_s;
	logic [DIV_SB-1:0] dp_sb_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_v_s <= 1'b0;
		end else if (en) begin
			dp_v_s <= rt_v[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_rem_s[i] <= (DW'(rm[i]) << F) + DW'(root >> 1);
			end
			dp_root_s <= root;
			dp_sb_s   <= rsb[SQ_SB-1 -: DIV_SB];
		end
	end

	wire              dv_v [QW+1];
	wire [DW-1:0]     dv_rem [QW+1][3];
	wire [QW-1:0]     dv_q [QW+1][3];
	wire [ROOT_W-1:0] dv_root [QW+1];
	wire [DIV_SB-1:0] dv_sb [QW+1];

	assign dv_v[0]    = dp_v_s;
	assign dv_rem[0]  = dp_rem_s;
	assign dv_q[0][0] = '0;
	assign dv_q[0][1] = '0;
	assign dv_q[0][2] = '0;
	assign dv_root[0] = dp_root_s;
	assign dv_sb[0]   = dp_sb_s;

	for (genvar j = 0; j < QW; j++) begin : g_dv
		obf_div_cell #(.POS(F - j), .DW(DW), .QW(QW), .SIDE_W(DIV_SB)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_v    (dv_v[j]),
			.rem_in  (dv_rem[j]),
			.q_in    (dv_q[j]),
			.root_in (dv_root[j]),
			.side_in (dv_sb[j]),
			.out_v   (dv_v[j+1]),
			.rem_out (dv_rem[j+1]),
			.q_out   (dv_q[j+1]),
			.root_out(dv_root[j+1]),
			.side_out(dv_sb[j+1])
		);
	end

	logic              fin_v_s;
	logic signed [F+1:0] fin_s [3];
	logic [SIDE_W-1:0] fin_d_s;
	logic [DIV_SB-1:0] fsb;
	logic signed [F+1:0] qs [3];

	assign fsb = dv_sb[QW];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs[i] = $signed({1'b0, dv_q[QW][i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else if (en) begin
			fin_v_s <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (fsb[3]) begin
					fin_s[i] <= '0;
				end else if (fsb[i]) begin
					fin_s[i] <= -qs[i];
				end else begin
					fin_s[i] <= qs[i];
				end
			end
			fin_d_s <= fsb[DIV_SB-1 -: SIDE_W];
		end
	end

	assign out_v    = fin_v_s;
	assign res      = fin_s;
	assign side_out = fin_d_s;

endmodule

// ----- hdl/orthonormal_basis_from_vector_core.sv -----
// ----------------------------------------------------------------------------
// Orthonormal basis from vector
// Builds b0, b1 and b2 in fixed point from one Q11.12 vector per word.
// ----------------------------------------------------------------------------
// vec_ch carries one vector and an already-unit flag per word; basis_ch
// returns the three basis vectors with OUT_FRAC_BITS fraction bits.
// cfg_ch writes the colinear epsilon and is always ready; write it only
// while no word is in flight.
// The datapath runs through two normalizers, each a chain of 32 square
// root cells followed by OUT_FRAC_BITS + 1 division cells. A new word is
// accepted in every cycle while the skid register is empty.
// Reset clears every valid flag and sets the epsilon to 16.
// When basis_ch stalls, one more word is caught in a skid register and
// then vec_ch ready drops; the whole pipeline holds until the skid drains.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_vector_core #(
	parameter int IN_WIDTH      = 24,
	parameter int OUT_FRAC_BITS = 14
) (
	input logic         clk,
	input logic         arst_n,
	obf_vec_if.sink     vec_ch,
	obf_basis_if.source basis_ch,
	obf_cfg_if.sink     cfg_ch
);
	import obf_pkg::*;

	localparam int F    = OUT_FRAC_BITS;
	localparam int BW   = F + 2;
	localparam int EW   = IN_WIDTH + F + 2;
	localparam int VW   = 2 * F + 3;
	localparam int MW2  = 2 * F + 2;
	localparam int PW   = 2 * BW;
	localparam int SIDE1 = 1 + 3 * BW;
	localparam int SIDE2 = 3 * BW;
	localparam logic signed [EW-1:0] ONE_E = EW'(1) <<< F;
	localparam logic signed [BW-1:0] ONE_B = BW'(1) <<< F;
	localparam logic signed [VW-1:0] ONE_SQ = VW'(1) <<< (2 * F);

	logic en;
	logic [EPS_W-1:0] eps_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_W'(EPS_RESET);
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			eps_q <= cfg_ch.data;
		end
	end

	logic signed [IN_WIDTH-1:0] raw [3];
	logic signed [EW-1:0]       ext [3];
	logic signed [EW-1:0]       conv [3];
	logic signed [BW-1:0]       cu [3];
	logic [IN_WIDTH-1:0]        mag1 [3];
	logic [2:0]                 neg1;

	assign raw[0] = vec_ch.vec_x;
	assign raw[1] = vec_ch.vec_y;
	assign raw[2] = vec_ch.vec_z;

	for (genvar i = 0; i < 3; i++) begin : g_in
		assign ext[i]  = EW'(raw[i]);
		assign neg1[i] = raw[i][IN_WIDTH-1];
		assign mag1[i] = neg1[i] ? IN_WIDTH'(-raw[i]) : IN_WIDTH'(raw[i]);

		if (F >= IN_FRAC) begin : g_up
			assign conv[i] = ext[i] <<< (F - IN_FRAC);
		end else begin : g_down
			localparam int SH = IN_FRAC - F;
			logic [EW-1:0] am;
			logic [EW-1:0] rnd;
			assign am  = neg1[i] ? EW'(-ext[i]) : EW'(ext[i]);
			assign rnd = (am + (EW'(1) << (SH - 1))) >> SH;
			assign conv[i] = neg1[i] ? -$signed(rnd) : $signed(rnd);
		end

		always_comb begin
			if (conv[i] > ONE_E) begin
				cu[i] = ONE_B;
			end else if (conv[i] < -ONE_E) begin
				cu[i] = -ONE_B;
			end else begin
				cu[i] = BW'(conv[i]);
			end
		end
	end

	assign vec_ch.ready = en;

	logic                n1_v;
	logic signed [BW-1:0] n1_res [3];
	logic [SIDE1-1:0]    n1_side;

	obf_norm #(.MAG_W(IN_WIDTH), .F(F), .SIDE_W(SIDE1)) u_norm0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (vec_ch.valid),
		.mag     (mag1),
		.neg     (neg1),
		.side    ({vec_ch.already_unit, cu[2], cu[1], cu[0]}),
		.out_v   (n1_v),
		.res     (n1_res),
		.side_out(n1_side)
	);

	logic                 p1_v_s, p2_v_s, p3_v_s;
	logic signed [BW-1:0] b0_s1 [3];
	logic signed [BW-1:0] b0_s2 [3];
	logic signed [BW-1:0] b0_s3 [3];
	logic signed [BW-1:0] temp_s2;
	logic                 col_s2, col_s3;
	logic signed [PW-1:0] prod_s3 [3];
	logic [BW-1:0]        ax;
	logic [BW-1:0]        diff;
	logic                 col;

	assign ax   = b0_s1[0][BW-1] ? BW'(-b0_s1[0]) : BW'(b0_s1[0]);
	assign diff = (ax >= BW'(ONE_B)) ? ax - BW'(ONE_B) : BW'(ONE_B) - ax;
	assign col  = 32'(diff) < 32'(eps_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_v_s <= 1'b0;
			p2_v_s <= 1'b0;
			p3_v_s <= 1'b0;
		end else if (en) begin
			p1_v_s <= n1_v;
			p2_v_s <= p1_v_s;
			p3_v_s <= p2_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				b0_s1[i] <= n1_side[SIDE1-1] ? $signed(n1_side[i*BW +: BW]) : n1_res[i];
				b0_s2[i] <= b0_s1[i];
				b0_s3[i] <= b0_s2[i];
				prod_s3[i] <= PW'(temp_s2) * PW'(b0_s2[i]);
			end
			col_s2  <= col;
			temp_s2 <= col ? b0_s1[1] : b0_s1[0];
			col_s3  <= col_s2;
		end
	end

	logic signed [VW-1:0] v [3];
	logic [MW2-1:0]       mag2 [3];
	logic [2:0]           neg2;

	assign v[0] = (col_s3 ? VW'(0) : ONE_SQ) - VW'(prod_s3[0]);
	assign v[1] = (col_s3 ? ONE_SQ : VW'(0)) - VW'(prod_s3[1]);
	assign v[2] = -VW'(prod_s3[2]);

	for (genvar i = 0; i < 3; i++) begin : g_v
		assign neg2[i] = v[i][VW-1];
		assign mag2[i] = neg2[i] ? MW2'(-v[i]) : MW2'(v[i]);
	end

	logic                 n2_v;
	logic signed [BW-1:0] n2_res [3];
	logic [SIDE2-1:0]     n2_side;

	obf_norm #(.MAG_W(MW2), .F(F), .SIDE_W(SIDE2)) u_norm1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (p3_v_s),
		.mag     (mag2),
		.neg     (neg2),
		.side    ({b0_s3[2], b0_s3[1], b0_s3[0]}),
		.out_v   (n2_v),
		.res     (n2_res),
		.side_out(n2_side)
	);

	logic                 c1_v_s, c2_v_s;
	logic signed [BW-1:0] b0_c1 [3];
	logic signed [BW-1:0] b1_c1 [3];
	logic signed [PW-1:0] pa_s1 [3];
	logic signed [PW-1:0] pb_s1 [3];
	logic signed [BW-1:0] b0_s4 [3];
	logic signed [BW-1:0] b1_s4 [3];
	logic signed [BW-1:0] b2_s4 [3];
	logic signed [BW-1:0] sb0 [3];
	logic signed [BW-1:0] b2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sb0[i] = $signed(n2_side[i*BW +: BW]);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_cr
		logic signed [PW:0] d;
		logic [PW:0]        ad;
		logic [PW:0]        rm;
		logic signed [BW-1:0] rb;
		assign d  = (PW+1)'(pa_s1[i]) - (PW+1)'(pb_s1[i]);
		assign ad = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
		assign rm = (ad + ((PW+1)'(1) << (F - 1))) >> F;
		assign rb = (rm > (PW+1)'(ONE_B)) ? ONE_B : $signed(BW'(rm));
		assign b2[i] = d[PW] ? -rb : rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_v_s <= 1'b0;
			c2_v_s <= 1'b0;
		end else if (en) begin
			c1_v_s <= n2_v;
			c2_v_s <= c1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b0_c1 <= sb0;
			b1_c1 <= n2_res;
			pa_s1[0] <= PW'(sb0[1]) * PW'(n2_res[2]);
			pb_s1[0] <= PW'(sb0[2]) * PW'(n2_res[1]);
			pa_s1[1] <= PW'(sb0[2]) * PW'(n2_res[0]);
			pb_s1[1] <= PW'(sb0[0]) * PW'(n2_res[2]);
			pa_s1[2] <= PW'(sb0[0]) * PW'(n2_res[1]);
			pb_s1[2] <= PW'(sb0[1]) * PW'(n2_res[0]);
			b0_s4 <= b0_c1;
			b1_s4 <= b1_c1;
			b2_s4 <= b2;
		end
	end

	word_t pd [OUT_WORDS];
	word_t out_d_q [OUT_WORDS];
	word_t skid_d_q [OUT_WORDS];
	logic  out_v_q;
	logic  skid_v_q;
	logic  take;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pd[i]     = OUT_W'(b0_s4[i]);
			pd[3 + i] = OUT_W'(b1_s4[i]);
			pd[6 + i] = OUT_W'(b2_s4[i]);
		end
	end

	assign en   = !skid_v_q;
	assign take = en && c2_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || basis_ch.ready) begin
			out_v_q  <= skid_v_q || take;
			skid_v_q <= 1'b0;
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || basis_ch.ready) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
			end else begin
				out_d_q <= pd;
			end
		end else if (take) begin
			skid_d_q <= pd;
		end
	end

	assign basis_ch.valid    = out_v_q;
	assign basis_ch.first_x  = out_d_q[0];
	assign basis_ch.first_y  = out_d_q[1];
	assign basis_ch.first_z  = out_d_q[2];
	assign basis_ch.second_x = out_d_q[3];
	assign basis_ch.second_y = out_d_q[4];
	assign basis_ch.second_z = out_d_q[5];
	assign basis_ch.third_x  = out_d_q[6];
	assign basis_ch.third_y  = out_d_q[7];
	assign basis_ch.third_z  = out_d_q[8];

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid word held without an output word.");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !basis_ch.ready))
		else $error("Skid filled while the output was free.");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(skid_v_q) |-> out_v_q)
		else $error("Skid word lost on drain.");

	a_b2_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		c2_v_s |-> (b2_s4[0] <= ONE_B && b2_s4[0] >= -ONE_B))
		else $error("Cross product left the unit range.");

endmodule
